// ===== rtl/core/region_state_bitmap_map_unit_assert.svh =====
// Assertion macros for the region state map unit
`ifndef REGION_STATE_BITMAP_MAP_UNIT_ASSERT_SVH
`define REGION_STATE_BITMAP_MAP_UNIT_ASSERT_SVH
// assert that a condition implies a consequence in the same cycle
`define RSM_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// assert that a condition implies a consequence in the next cycle
`define RSM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/core/rsm_pkg.sv =====
// Package: types, constants and codes of the region state map unit
`default_nettype none
package rsm_pkg;
	localparam int MaxRegions = 1024;
	localparam int WordBits = 64;
	localparam int Words = MaxRegions / WordBits;
	localparam int WordIdxW = $clog2(Words);
	localparam int BitIdxW = $clog2(WordBits);
	localparam int CntW = $clog2(MaxRegions) + 1;
	localparam int PopW = $clog2(WordBits) + 1;

	localparam logic [2:0] KIND_ACTIVATE = 3'd0;
	localparam logic [2:0] KIND_REACTIVATE = 3'd1;
	localparam logic [2:0] KIND_DEACTIVATE = 3'd2;
	localparam logic [2:0] KIND_FREE = 3'd3;
	localparam logic [2:0] KIND_NEXT_ACTIVE = 3'd4;
	localparam logic [2:0] KIND_NEXT_FREE = 3'd5;
	localparam logic [2:0] KIND_NEXT_INACTIVE = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_STATE = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [CntW-1:0] range_begin;
		logic [CntW-1:0] range_limit;
	} req_t;

	typedef struct packed {
		logic [CntW-1:0] found_start;
		logic [CntW-1:0] found_end;
		logic [1:0] status;
		logic [CntW-1:0] active_total;
		logic [CntW-1:0] inactive_total;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
		logic finish;
		logic [WordIdxW-1:0] word;
	} cmd_t;

	typedef struct packed {
		logic is_range;
		logic is_query;
		logic bad;
		logic check_fail;
		logic query_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/rsm_ctrl.sv =====
// Controller: sequences word scans for check, apply and search
`default_nettype none
`include "region_state_bitmap_map_unit_assert.svh"
module rsm_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	output rsm_pkg::cmd_t cmd,
	input wire rsm_pkg::sts_t sts
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_CHECK = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_SEARCH = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;
	localparam logic [rsm_pkg::WordIdxW-1:0] LastWord = rsm_pkg::WordIdxW'(rsm_pkg::Words - 1);

	logic [2:0] state_q;
	logic [rsm_pkg::WordIdxW-1:0] word_q;
	logic last;

	assign last = (word_q == LastWord);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.word = word_q;
		cmd.load = (state_q == S_IDLE) && start;
		cmd.scan = (state_q == S_CHECK) || (state_q == S_SEARCH);
		cmd.apply = (state_q == S_APPLY);
		cmd.finish = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			word_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					word_q <= '0;
					if (start) state_q <= S_DECODE;
				end
				S_DECODE: begin
					word_q <= '0;
					if (sts.bad) state_q <= S_DONE;
					else if (sts.is_range) state_q <= S_CHECK;
					else if (sts.is_query) state_q <= S_SEARCH;
					else state_q <= S_DONE;
				end
				S_CHECK: begin
					word_q <= word_q + 1'b1;
					if (last) begin
						word_q <= '0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					word_q <= word_q + 1'b1;
					if (sts.check_fail || last) state_q <= S_DONE;
				end
				S_SEARCH: begin
					word_q <= word_q + 1'b1;
					if (sts.query_done || last) state_q <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RSM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`RSM_ASSERT_NEXT(a_done_idle, clk, arst_n, state_q == S_DONE, !busy, "done not idle")
	`RSM_ASSERT_IMP(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.scan, cmd.apply, cmd.finish}), "commands overlap")
endmodule
`default_nettype wire

// ===== rtl/core/rsm_dp.sv =====
// Datapath: bitmaps, counts, range masks and run search
`default_nettype none
module rsm_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire rsm_pkg::req_t req,
	input wire logic [rsm_pkg::CntW-1:0] region_count,
	input wire rsm_pkg::cmd_t cmd,
	output rsm_pkg::sts_t sts,
	output logic done,
	output rsm_pkg::rsp_t rsp
);
	localparam int W = rsm_pkg::WordBits;
	localparam int CW = rsm_pkg::CntW;
	localparam logic [CW-1:0] MaxN = CW'(rsm_pkg::MaxRegions);

	logic [W-1:0] act_q [rsm_pkg::Words];
	logic [W-1:0] ina_q [rsm_pkg::Words];
	logic [rsm_pkg::Words-1:0] act_vld_q, ina_vld_q;
	logic [CW-1:0] act_cnt_q, ina_cnt_q;
	rsm_pkg::req_t req_q;
	logic [CW-1:0] n_q;
	logic fail_q, bad_q, ina_any_q, found_q, in_run_q, query_done_q;
	logic [CW-1:0] fs_q, fe_q;

	logic [W-1:0] a_w, i_w, base, rmask, nmask, map_w, hit, miss_w;
	logic [CW-1:0] wbase, eff_n, len;
	logic is_range, is_query;
	logic [2:0] k;
	logic [rsm_pkg::BitIdxW-1:0] first_hit, first_miss;
	logic any_hit, any_miss, want;

	assign k = req_q.kind;
	assign is_range = (k <= rsm_pkg::KIND_FREE);
	assign is_query = (k >= rsm_pkg::KIND_NEXT_ACTIVE) && (k <= rsm_pkg::KIND_NEXT_INACTIVE);
	assign a_w = act_vld_q[cmd.word] ? act_q[cmd.word] : '0;
	assign i_w = ina_vld_q[cmd.word] ? ina_q[cmd.word] : '0;
	assign wbase = CW'({cmd.word, {rsm_pkg::BitIdxW{1'b0}}});
	assign len = req_q.range_limit - req_q.range_begin;

	always_comb begin
		eff_n = region_count;
		if (region_count == '0) eff_n = CW'(1);
		if (region_count > MaxN) eff_n = MaxN;
	end

	always_comb begin
		for (int b = 0; b < W; b++) begin
			rmask[b] = ((wbase + CW'(b)) >= req_q.range_begin) &&
				((wbase + CW'(b)) < req_q.range_limit);
			nmask[b] = ((wbase + CW'(b)) < n_q);
			base[b] = ((wbase + CW'(b)) >= req_q.range_begin);
		end
	end

	assign want = (k != rsm_pkg::KIND_NEXT_FREE);
	assign map_w = (k == rsm_pkg::KIND_NEXT_INACTIVE) ? i_w : a_w;
	assign hit = (want ? map_w : ~map_w) & nmask;
	assign miss_w = ~(want ? map_w : ~map_w) & nmask;

	always_comb begin
		first_hit = '0;
		any_hit = 1'b0;
		first_miss = '0;
		any_miss = 1'b0;
		for (int b = W - 1; b >= 0; b--) begin
			if (hit[b] && (base[b] || found_q) && !in_run_q) begin
				first_hit = rsm_pkg::BitIdxW'(b);
				any_hit = 1'b1;
			end
		end
		for (int b = W - 1; b >= 0; b--) begin
			if (miss_w[b] && (!any_hit || rsm_pkg::BitIdxW'(b) > first_hit)) begin
				first_miss = rsm_pkg::BitIdxW'(b);
				any_miss = 1'b1;
			end
		end
		if (!any_hit && !in_run_q) any_miss = 1'b0;
		if (!in_run_q && !any_hit) first_miss = '0;
		if (in_run_q && !any_hit) begin
			any_miss = 1'b0;
			for (int b = W - 1; b >= 0; b--) begin
				if (miss_w[b]) begin
					first_miss = rsm_pkg::BitIdxW'(b);
					any_miss = 1'b1;
				end
			end
		end
	end

	assign sts.is_range = is_range;
	assign sts.is_query = is_query;
	assign sts.bad = bad_q;
	assign sts.check_fail = fail_q;
	assign sts.query_done = query_done_q && (k != rsm_pkg::KIND_NEXT_FREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_vld_q <= '0;
			ina_vld_q <= '0;
			act_cnt_q <= '0;
			ina_cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
			if (cmd.apply && !fail_q && !bad_q) begin
				act_vld_q[cmd.word] <= 1'b1;
				ina_vld_q[cmd.word] <= 1'b1;
				if (cmd.word == '0) begin
					case (k)
						rsm_pkg::KIND_ACTIVATE: act_cnt_q <= act_cnt_q + len;
						rsm_pkg::KIND_REACTIVATE: begin
							act_cnt_q <= act_cnt_q + len;
							ina_cnt_q <= ina_cnt_q - len;
						end
						rsm_pkg::KIND_DEACTIVATE: begin
							act_cnt_q <= act_cnt_q - len;
							ina_cnt_q <= ina_cnt_q + len;
						end
						rsm_pkg::KIND_FREE: ina_cnt_q <= ina_cnt_q - len;
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && !fail_q && !bad_q) begin
			case (k)
				rsm_pkg::KIND_ACTIVATE: act_q[cmd.word] <= a_w | rmask;
				rsm_pkg::KIND_REACTIVATE: begin
					act_q[cmd.word] <= a_w | rmask;
					ina_q[cmd.word] <= i_w & ~rmask;
				end
				rsm_pkg::KIND_DEACTIVATE: begin
					act_q[cmd.word] <= a_w & ~rmask;
					ina_q[cmd.word] <= i_w | rmask;
				end
				default: ina_q[cmd.word] <= i_w & ~rmask;
			endcase
			if (k == rsm_pkg::KIND_ACTIVATE) ina_q[cmd.word] <= i_w;
			if (k == rsm_pkg::KIND_FREE) act_q[cmd.word] <= a_w;
		end
		if (cmd.load) begin
			req_q <= req;
			n_q <= eff_n;
			fail_q <= 1'b0;
			found_q <= 1'b0;
			in_run_q <= 1'b0;
			query_done_q <= 1'b0;
			ina_any_q <= 1'b0;
			bad_q <= (req.kind <= rsm_pkg::KIND_FREE) ?
				((req.range_begin > req.range_limit) || (req.range_limit > eff_n)) :
				(req.range_begin > eff_n);
			fs_q <= eff_n;
			fe_q <= eff_n;
		end
		if (cmd.scan && is_range) begin
			if ((a_w & rmask) != ((k == rsm_pkg::KIND_DEACTIVATE) ? rmask : '0)) fail_q <= 1'b1;
			if ((i_w & rmask) != (((k == rsm_pkg::KIND_REACTIVATE) || (k == rsm_pkg::KIND_FREE)) ? rmask : '0))
				fail_q <= 1'b1;
		end
		if (cmd.scan && is_query) begin
			if ((i_w & nmask) != '0) ina_any_q <= 1'b1;
			if (!query_done_q) begin
				if (any_hit) begin
					found_q <= 1'b1;
					fs_q <= wbase + CW'(first_hit);
					in_run_q <= 1'b1;
				end
				if (any_miss) begin
					fe_q <= wbase + CW'(first_miss);
					query_done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		rsp = '0;
		rsp.active_total = act_cnt_q;
		rsp.inactive_total = ina_cnt_q;
		if (is_range) begin
			rsp.status = bad_q ? rsm_pkg::ST_RANGE : (fail_q ? rsm_pkg::ST_STATE : rsm_pkg::ST_OK);
		end else if (is_query) begin
			if (bad_q) begin
				rsp.found_start = n_q;
				rsp.found_end = n_q;
				rsp.status = rsm_pkg::ST_RANGE;
			end else begin
				rsp.found_start = fs_q;
				rsp.found_end = in_run_q ? fe_q : n_q;
				rsp.status = (k == rsm_pkg::KIND_NEXT_FREE && ina_any_q) ? rsm_pkg::ST_STATE : rsm_pkg::ST_OK;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/region_state_bitmap_map_unit.sv =====
// Top level of the region state map unit
//  channel   | handshake              | payload
//  request   | start / busy           | req (kind, range_begin, range_limit)
//  result    | done (one-cycle pulse) | rsp (found fields, status, totals)
//  config    | APB psel/penable/pwrite| region_count at address 0
// A range operation runs decode, check and apply passes over the 16 words, done and
// result; a failed check ends the apply pass at its first word, a bad range goes to done
// after decode. One 64-bit bitmap word is handled per cycle; next free scans all words.
// Reset clears both maps through per-word valid bits at once; no clearing pass.
// Query searches on a bad query offset finish after decode. The receiver cannot stall.
`default_nettype none
module region_state_bitmap_map_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rsm_pkg::req_t req,
	output logic done,
	output rsm_pkg::rsp_t rsp,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	rsm_pkg::cmd_t cmd;
	rsm_pkg::sts_t sts;
	logic [rsm_pkg::CntW-1:0] region_count_q;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {{(32 - rsm_pkg::CntW){1'b0}}, region_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) region_count_q <= rsm_pkg::CntW'(rsm_pkg::MaxRegions);
		else if (psel && penable && pwrite && paddr == 2'd0) region_count_q <= pwdata[rsm_pkg::CntW-1:0];
	end

	rsm_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts));
	rsm_dp u_dp (.clk(clk), .arst_n(arst_n), .req(req), .region_count(region_count_q), .cmd(cmd),
		.sts(sts), .done(done), .rsp(rsp));
endmodule
`default_nettype wire
